### hdl/assert_macros.svh
// Assertion macros used by the transceiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define DMT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define DMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DMT_ASSERT(lbl, clk, rst_n, prop, msg)

`define DMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/dmt_pkg.sv
// Types, codes and reset constants of the DALI Manchester transceiver.
`default_nettype none

package dmt_pkg;

	typedef enum logic [1:0] {
		FUNC_EDGE = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_SEND = 2'd2,
		FUNC_ACK  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		RX_IDLE     = 3'd0,
		RX_START_H1 = 3'd1,
		RX_START_H2 = 3'd2,
		RX_FIRST    = 3'd3,
		RX_SECOND   = 3'd4,
		RX_READY    = 3'd5,
		RX_ERROR    = 3'd6,
		RX_SENDING  = 3'd7
	} rx_state_t;

	typedef enum logic [2:0] {
		TX_NONE    = 3'd0,
		TX_START   = 3'd1,
		TX_DATA    = 3'd2,
		TX_STOP    = 3'd3,
		TX_SUCCESS = 3'd4,
		TX_FAILED  = 3'd5
	} tx_state_t;

	typedef enum logic [2:0] {
		CL_SHORT   = 3'd0,
		CL_HALF    = 3'd1,
		CL_INVALID = 3'd2,
		CL_TWO     = 3'd3,
		CL_LONG    = 3'd4
	} class_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_START_H1     = 3'd1,
		ERR_DATA_H1_ONE  = 3'd2,
		ERR_DATA_H2_ZERO = 3'd3,
		ERR_START_H2     = 3'd4,
		ERR_DATA_H1_ZERO = 3'd5,
		ERR_DATA_H2_ONE  = 3'd6,
		ERR_STOP         = 3'd7
	} err_code_t;

	// configuration register indexes
	localparam logic [2:0] REG_HALF_BIT_MIN = 3'd0;
	localparam logic [2:0] REG_HALF_BIT_MAX = 3'd1;
	localparam logic [2:0] REG_TWO_HALF_MIN = 3'd2;
	localparam logic [2:0] REG_TWO_HALF_MAX = 3'd3;
	localparam logic [2:0] REG_HALF_TICKS   = 3'd4;
	localparam logic [2:0] REG_STOP_TICKS   = 3'd5;

	localparam logic [15:0] RST_HALF_BIT_MIN = 16'd303;
	localparam logic [15:0] RST_HALF_BIT_MAX = 16'd530;
	localparam logic [15:0] RST_TWO_HALF_MIN = 16'd636;
	localparam logic [15:0] RST_TWO_HALF_MAX = 16'd1030;
	localparam logic [15:0] RST_HALF_TICKS   = 16'd1;
	localparam logic [15:0] RST_STOP_TICKS   = 16'd4;

	localparam logic [5:0] RX_COUNT_MAX = 6'd63;

	typedef struct packed {
		logic [15:0] half_bit_min;
		logic [15:0] half_bit_max;
		logic [15:0] two_half_min;
		logic [15:0] two_half_max;
	} dmt_limits_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        line_level;
		logic [31:0] time_us;
		logic [31:0] send_pattern;
		logic [5:0]  send_count;
	} dmt_in_t;

	typedef struct packed {
		logic        drive_short;
		logic [2:0]  receive_state;
		logic [2:0]  send_status;
		logic [31:0] frame_value;
		logic [5:0]  frame_bits;
		logic [2:0]  error_code;
		logic [2:0]  error_timing;
		logic [2:0]  error_state;
	} dmt_out_t;

endpackage

`default_nettype wire

### hdl/dmt_classify.sv
// Edge spacing classifier: distance between two timestamps against four limits.
`default_nettype none

module dmt_classify (
	input  wire logic [31:0]         time_a,
	input  wire logic [31:0]         time_b,
	input  wire dmt_pkg::dmt_limits_t limits,
	output dmt_pkg::class_t          cls
);
	import dmt_pkg::*;

	logic [31:0] span;

	assign span = (time_a > time_b) ? (time_a - time_b) : (time_b - time_a);

	always_comb begin
		if (span < 32'(limits.half_bit_min)) begin
			cls = CL_SHORT;
		end else if (span < 32'(limits.half_bit_max)) begin
			cls = CL_HALF;
		end else if (span < 32'(limits.two_half_min)) begin
			cls = CL_INVALID;
		end else if (span < 32'(limits.two_half_max)) begin
			cls = CL_TWO;
		end else begin
			cls = CL_LONG;
		end
	end

endmodule

`default_nettype wire

### hdl/dali_manchester_transceiver_core.sv
// DALI Manchester bus transceiver: receive decoder, sender and collision check.
//
//  channel | signals                        | dir | payload
//  --------+--------------------------------+-----+-------------------------------
//  in      | in_valid / in_ready / in_data  | in  | edge, tick, send or ack event
//  out     | out_valid / out_ready/ out_data| out | pin, states, frame, error info
//  cfg     | cfg_we / cfg_idx / cfg_data    | in  | six 16-bit timing registers
//
// One event per cycle while the result side is not stalled. An accepted beat is held in the
// input register, then a single pass of compare/shift logic updates the state registers, which
// also form the result beat; out_valid rises when the state registers take that beat.
// A stalled result still lets one more event into the input register.
// arst_n clears all state; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module dali_manchester_transceiver_core #(
	parameter int MAX_HALF_BITS = 32,
	parameter int TIMER_WIDTH   = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dmt_pkg::dmt_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dmt_pkg::dmt_out_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_idx,
	input  wire logic [15:0]       cfg_data
);
	import dmt_pkg::*;

	localparam int TXL_W = $clog2(MAX_HALF_BITS + 1);

	// configuration
	logic [15:0] half_bit_min_q, half_bit_max_q, two_half_min_q, two_half_max_q;
	logic [15:0] half_ticks_q, stop_ticks_q;

	// input stage
	dmt_in_t item_s1;
	logic    valid_s1;
	logic    adv;

	// transceiver state
	rx_state_t            rx_state_q, rx_state_n;
	tx_state_t            tx_state_q, tx_state_n;
	logic [31:0]          last_high_q, last_high_n;
	logic [31:0]          last_low_q, last_low_n;
	logic [31:0]          low_at_high_q, low_at_high_n;
	logic                 watch_q, watch_n;
	logic [31:0]          tx_pattern_q, tx_pattern_n;
	logic [TXL_W-1:0]     tx_left_q, tx_left_n;
	logic [31:0]          rx_value_q, rx_value_n;
	logic [5:0]           rx_count_q, rx_count_n;
	logic [TIMER_WIDTH-1:0] timer_q, timer_n;
	logic                 drive_q, drive_n;
	err_code_t            err_code_q, err_code_n;
	class_t               err_timing_q, err_timing_n;
	logic [2:0]           err_state_q, err_state_n;
	logic                 out_valid_q;

	// helpers
	dmt_limits_t          limits;
	class_t               cls;
	logic [31:0]          other_time;
	logic [TIMER_WIDTH-1:0] half_raw, stop_raw, half_ld, stop_ld;
	logic [5:0]           count_inc;
	logic [TXL_W-1:0]     send_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_min_q <= RST_HALF_BIT_MIN;
			half_bit_max_q <= RST_HALF_BIT_MAX;
			two_half_min_q <= RST_TWO_HALF_MIN;
			two_half_max_q <= RST_TWO_HALF_MAX;
			half_ticks_q   <= RST_HALF_TICKS;
			stop_ticks_q   <= RST_STOP_TICKS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HALF_BIT_MIN: half_bit_min_q <= cfg_data;
				REG_HALF_BIT_MAX: half_bit_max_q <= cfg_data;
				REG_TWO_HALF_MIN: two_half_min_q <= cfg_data;
				REG_TWO_HALF_MAX: two_half_max_q <= cfg_data;
				REG_HALF_TICKS:   half_ticks_q   <= cfg_data;
				REG_STOP_TICKS:   stop_ticks_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: input register drains into the state/result registers
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// spacing class against the opposite edge's last timestamp
	assign limits = '{half_bit_min: half_bit_min_q, half_bit_max: half_bit_max_q,
		two_half_min: two_half_min_q, two_half_max: two_half_max_q};
	assign other_time = item_s1.line_level ? last_high_q : last_low_q;

	dmt_classify u_classify (
		.time_a (item_s1.time_us),
		.time_b (other_time),
		.limits (limits),
		.cls    (cls)
	);

	// a zero timer length after masking loads as one
	assign half_raw = TIMER_WIDTH'(half_ticks_q);
	assign stop_raw = TIMER_WIDTH'(stop_ticks_q);
	assign half_ld  = (half_raw == '0) ? TIMER_WIDTH'(1) : half_raw;
	assign stop_ld  = (stop_raw == '0) ? TIMER_WIDTH'(1) : stop_raw;

	assign count_inc = (rx_count_q < RX_COUNT_MAX) ? (rx_count_q + 6'd1) : rx_count_q;
	assign send_left = (32'(item_s1.send_count) > MAX_HALF_BITS) ?
		TXL_W'(MAX_HALF_BITS) : TXL_W'(item_s1.send_count);

	always_comb begin
		rx_state_n    = rx_state_q;
		tx_state_n    = tx_state_q;
		last_high_n   = last_high_q;
		last_low_n    = last_low_q;
		low_at_high_n = low_at_high_q;
		watch_n       = watch_q;
		tx_pattern_n  = tx_pattern_q;
		tx_left_n     = tx_left_q;
		rx_value_n    = rx_value_q;
		rx_count_n    = rx_count_q;
		timer_n       = timer_q;
		drive_n       = drive_q;
		err_code_n    = err_code_q;
		err_timing_n  = err_timing_q;
		err_state_n   = err_state_q;

		case (func_t'(item_s1.func))
			FUNC_EDGE: begin
				if (!item_s1.line_level) begin
					// DALI high edge
					last_high_n = item_s1.time_us;
					case (rx_state_q)
						RX_START_H1: begin
							if (cls == CL_HALF) begin
								rx_state_n = RX_START_H2;
							end else begin
								err_code_n = ERR_START_H1; err_timing_n = cls;
								rx_state_n = RX_ERROR;
							end
						end
						RX_FIRST: begin
							if (cls == CL_HALF) begin
								rx_state_n = RX_SECOND;
								timer_n    = stop_ld;
							end else begin
								err_code_n = ERR_DATA_H1_ONE; err_timing_n = cls;
								rx_state_n = RX_ERROR;
							end
						end
						RX_SECOND: begin
							if (cls == CL_HALF || cls == CL_TWO) begin
								rx_value_n = {rx_value_q[30:0], 1'b0};
								rx_count_n = count_inc;
								timer_n    = stop_ld;
								if (cls == CL_HALF) begin
									rx_state_n = RX_FIRST;
								end
							end else begin
								err_code_n = ERR_DATA_H2_ZERO; err_timing_n = cls;
								rx_state_n = RX_ERROR;
							end
						end
						default: ;
					endcase
				end else begin
					// DALI low edge
					last_low_n = item_s1.time_us;
					if (rx_state_q != RX_SENDING) begin
						timer_n = '0;
					end
					case (rx_state_q)
						RX_IDLE: begin
							rx_state_n = RX_START_H1;
							rx_value_n = '0;
							rx_count_n = '0;
						end
						RX_START_H2: begin
							if (cls == CL_HALF) begin
								rx_state_n = RX_FIRST;
							end else if (cls == CL_TWO) begin
								rx_state_n = RX_SECOND;
							end else begin
								err_code_n = ERR_START_H2; err_timing_n = cls;
								rx_state_n = RX_ERROR;
							end
						end
						RX_FIRST: begin
							if (cls == CL_HALF) begin
								rx_state_n = RX_SECOND;
							end else begin
								err_code_n = ERR_DATA_H1_ZERO; err_timing_n = cls;
								rx_state_n = RX_ERROR;
							end
						end
						RX_SECOND: begin
							if (cls == CL_HALF || cls == CL_TWO) begin
								rx_value_n = {rx_value_q[30:0], 1'b1};
								rx_count_n = count_inc;
								if (cls == CL_HALF) begin
									rx_state_n = RX_FIRST;
								end
							end else begin
								err_code_n = ERR_DATA_H2_ONE; err_timing_n = cls;
								rx_state_n = RX_ERROR;
							end
						end
						default: ;
					endcase
				end
			end
			FUNC_TICK: begin
				if (timer_q != '0) begin
					timer_n = timer_q - TIMER_WIDTH'(1);
					if (timer_q == TIMER_WIDTH'(1)) begin
						if (rx_state_q == RX_SENDING) begin
							if (watch_q && last_low_q != low_at_high_q) begin
								// someone pulled the bus low while we released it
								tx_state_n = TX_FAILED;
								rx_state_n = RX_START_H1;
								rx_value_n = '0;
								rx_count_n = '0;
								watch_n    = 1'b0;
							end else begin
								case (tx_state_q)
									TX_START: begin
										drive_n       = 1'b0;
										low_at_high_n = last_low_q;
										watch_n       = 1'b1;
										tx_state_n    = TX_DATA;
										timer_n       = half_ld;
									end
									TX_DATA: begin
										if (tx_left_q == '0) begin
											drive_n       = 1'b0;
											low_at_high_n = last_low_q;
											watch_n       = 1'b1;
											tx_state_n    = TX_STOP;
											timer_n       = stop_ld;
										end else begin
											if (tx_pattern_q[0]) begin
												drive_n       = 1'b0;
												low_at_high_n = last_low_q;
												watch_n       = 1'b1;
											end else begin
												drive_n = 1'b1;
												watch_n = 1'b0;
											end
											tx_pattern_n = {1'b0, tx_pattern_q[31:1]};
											tx_left_n    = tx_left_q - TXL_W'(1);
											timer_n      = half_ld;
										end
									end
									TX_STOP: begin
										tx_state_n = TX_SUCCESS;
										rx_state_n = RX_IDLE;
									end
									default: ;
								endcase
							end
						end else begin
							// stop condition on the receive side
							case (rx_state_q)
								RX_SECOND: begin
									rx_value_n = {rx_value_q[30:0], 1'b1};
									rx_count_n = count_inc;
									rx_state_n = RX_READY;
								end
								RX_FIRST: begin
									rx_state_n = RX_READY;
								end
								default: begin
									err_state_n = rx_state_q;
									err_code_n  = ERR_STOP;
									rx_state_n  = RX_ERROR;
								end
							endcase
						end
					end
				end
			end
			FUNC_SEND: begin
				tx_pattern_n = item_s1.send_pattern;
				tx_left_n    = send_left;
				rx_state_n   = RX_SENDING;
				tx_state_n   = TX_START;
				drive_n      = 1'b1;
				watch_n      = 1'b0;
				timer_n      = half_ld;
			end
			FUNC_ACK: begin
				if (rx_state_q == RX_READY || rx_state_q == RX_ERROR) begin
					rx_state_n   = RX_IDLE;
					err_code_n   = ERR_NONE;
					err_timing_n = CL_SHORT;
					err_state_n  = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q    <= RX_IDLE;
			tx_state_q    <= TX_NONE;
			last_high_q   <= '0;
			last_low_q    <= '0;
			low_at_high_q <= '0;
			watch_q       <= 1'b0;
			tx_pattern_q  <= '0;
			tx_left_q     <= '0;
			rx_value_q    <= '0;
			rx_count_q    <= '0;
			timer_q       <= '0;
			drive_q       <= 1'b0;
			err_code_q    <= ERR_NONE;
			err_timing_q  <= CL_SHORT;
			err_state_q   <= '0;
		end else if (adv) begin
			rx_state_q    <= rx_state_n;
			tx_state_q    <= tx_state_n;
			last_high_q   <= last_high_n;
			last_low_q    <= last_low_n;
			low_at_high_q <= low_at_high_n;
			watch_q       <= watch_n;
			tx_pattern_q  <= tx_pattern_n;
			tx_left_q     <= tx_left_n;
			rx_value_q    <= rx_value_n;
			rx_count_q    <= rx_count_n;
			timer_q       <= timer_n;
			drive_q       <= drive_n;
			err_code_q    <= err_code_n;
			err_timing_q  <= err_timing_n;
			err_state_q   <= err_state_n;
		end
	end

	// state only moves on a processed beat, so it doubles as the result
	assign out_valid              = out_valid_q;
	assign out_data.drive_short   = drive_q;
	assign out_data.receive_state = rx_state_q;
	assign out_data.send_status   = tx_state_q;
	assign out_data.frame_value   = rx_value_q;
	assign out_data.frame_bits    = rx_count_q;
	assign out_data.error_code    = err_code_q;
	assign out_data.error_timing  = err_timing_q;
	assign out_data.error_state   = err_state_q;

	`DMT_ASSERT(a_drive_only_sending, clk, arst_n, !drive_q || rx_state_q == RX_SENDING, "bus driven low outside sending")
	`DMT_ASSERT(a_watch_released, clk, arst_n, !watch_q || !drive_q, "collision watch armed while driving low")
	`DMT_ASSERT(a_tx_active_sending, clk, arst_n, !(tx_state_q == TX_START || tx_state_q == TX_DATA || tx_state_q == TX_STOP) || rx_state_q == RX_SENDING, "sender active while receiver not in sending")
	`DMT_ASSERT_NEXT(a_result_held, clk, arst_n, !adv, $stable(rx_value_q) && $stable(rx_state_q) && $stable(timer_q), "state changed without a processed beat")
	`DMT_ASSERT_NEXT(a_item_kept, clk, arst_n, valid_s1 && !adv, valid_s1, "input beat dropped while stalled")

endmodule

`default_nettype wire

### tb/dali_manchester_transceiver_core_test.sv
`timescale 1ns / 100ps
// Testbench of the DALI transceiver core: line-state predictor, traffic tasks and checks.
module dali_manchester_transceiver_core_test;
	import dmt_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_MSGS    = 200;

	// Mirrors the transceiver state and keeps the status beats still owed by the block.
	class xcvr_scoreboard;
		logic [15:0] lim_half_min = RST_HALF_BIT_MIN;
		logic [15:0] lim_half_max = RST_HALF_BIT_MAX;
		logic [15:0] lim_two_min  = RST_TWO_HALF_MIN;
		logic [15:0] lim_two_max  = RST_TWO_HALF_MAX;
		logic [15:0] half_ticks   = RST_HALF_TICKS;
		logic [15:0] stop_ticks   = RST_STOP_TICKS;

		rx_state_t   rx          = RX_IDLE;
		tx_state_t   tx          = TX_NONE;
		logic [31:0] t_high      = '0;
		logic [31:0] t_low       = '0;
		logic [31:0] t_low_watch = '0;
		bit          watch       = 1'b0;
		logic [31:0] tx_bits     = '0;
		int unsigned tx_left     = 0;
		logic [31:0] frame       = '0;
		logic [5:0]  nbits       = '0;
		logic [15:0] timer       = '0;
		logic        drive       = 1'b0;
		err_code_t   err_code    = ERR_NONE;
		class_t      err_class   = CL_SHORT;
		rx_state_t   err_state   = RX_IDLE;

		dmt_out_t    status_q[$];
		int unsigned fails = 0;
		int unsigned frames_ok = 0, rx_errors = 0, sends_ok = 0, collisions = 0;

		function int pending();
			return status_q.size();
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				REG_HALF_BIT_MIN: lim_half_min = v;
				REG_HALF_BIT_MAX: lim_half_max = v;
				REG_TWO_HALF_MIN: lim_two_min = v;
				REG_TWO_HALF_MAX: lim_two_max = v;
				REG_HALF_TICKS:   half_ticks = v;
				REG_STOP_TICKS:   stop_ticks = v;
				default: ;
			endcase
		endfunction

		// a zero length would never expire, so the timer starts at one
		function logic [15:0] load(logic [15:0] v);
			return (v == '0) ? 16'd1 : v;
		endfunction

		function class_t spacing();
			logic [31:0] d;
			d = (t_high > t_low) ? t_high - t_low : t_low - t_high;
			if (d < lim_half_min) return CL_SHORT;
			if (d < lim_half_max) return CL_HALF;
			if (d < lim_two_min) return CL_INVALID;
			if (d < lim_two_max) return CL_TWO;
			return CL_LONG;
		endfunction

		function void take_bit(logic b);
			if (nbits < RX_COUNT_MAX) nbits++;
			frame = {frame[30:0], b};
		endfunction

		function void fail_rx(err_code_t c, class_t k);
			err_code = c;
			err_class = k;
			rx = RX_ERROR;
			rx_errors++;
		endfunction

		function void rise(logic [31:0] t);
			class_t c;
			t_high = t;
			if (rx == RX_SENDING) return;
			c = spacing();
			case (rx)
				RX_START_H1: begin
					if (c == CL_HALF) rx = RX_START_H2;
					else fail_rx(ERR_START_H1, c);
				end
				RX_FIRST: begin
					if (c == CL_HALF) begin
						rx = RX_SECOND;
						timer = load(stop_ticks);
					end else fail_rx(ERR_DATA_H1_ONE, c);
				end
				RX_SECOND: begin
					if (c == CL_HALF) begin
						take_bit(1'b0);
						rx = RX_FIRST;
						timer = load(stop_ticks);
					end else if (c == CL_TWO) begin
						take_bit(1'b0);
						timer = load(stop_ticks);
					end else fail_rx(ERR_DATA_H2_ZERO, c);
				end
				default: ;
			endcase
		endfunction

		function void fall(logic [31:0] t);
			class_t c;
			t_low = t;
			if (rx == RX_SENDING) return;
			timer = '0;
			c = spacing();
			case (rx)
				RX_IDLE: begin
					rx = RX_START_H1;
					frame = '0;
					nbits = '0;
				end
				RX_START_H2: begin
					if (c == CL_HALF) rx = RX_FIRST;
					else if (c == CL_TWO) rx = RX_SECOND;
					else fail_rx(ERR_START_H2, c);
				end
				RX_FIRST: begin
					if (c == CL_HALF) rx = RX_SECOND;
					else fail_rx(ERR_DATA_H1_ZERO, c);
				end
				RX_SECOND: begin
					if (c == CL_HALF) begin
						take_bit(1'b1);
						rx = RX_FIRST;
					end else if (c == CL_TWO) take_bit(1'b1);
					else fail_rx(ERR_DATA_H2_ONE, c);
				end
				default: ;
			endcase
		endfunction

		function void stop_seen();
			if (rx == RX_SECOND) begin
				take_bit(1'b1);
				rx = RX_READY;
				frames_ok++;
			end else if (rx == RX_FIRST) begin
				rx = RX_READY;
				frames_ok++;
			end else begin
				err_state = rx;
				err_code = ERR_STOP;
				rx = RX_ERROR;
				rx_errors++;
			end
		endfunction

		// release the bus and remember the last low edge to spot a collision
		function void release_bus();
			drive = 1'b0;
			t_low_watch = t_low;
			watch = 1'b1;
		endfunction

		function void next_half();
			if (watch && t_low != t_low_watch) begin
				tx = TX_FAILED;
				rx = RX_START_H1;
				frame = '0;
				nbits = '0;
				watch = 1'b0;
				collisions++;
				return;
			end
			if (tx == TX_START) begin
				release_bus();
				tx = TX_DATA;
				timer = load(half_ticks);
			end else if (tx == TX_DATA) begin
				if (tx_left == 0) begin
					release_bus();
					tx = TX_STOP;
					timer = load(stop_ticks);
				end else begin
					if (tx_bits[0]) release_bus();
					else begin
						drive = 1'b1;
						watch = 1'b0;
					end
					tx_bits = tx_bits >> 1;
					tx_left--;
					timer = load(half_ticks);
				end
			end else if (tx == TX_STOP) begin
				tx = TX_SUCCESS;
				rx = RX_IDLE;
				sends_ok++;
			end
		endfunction

		function void tick();
			if (timer == '0) return;
			timer--;
			if (timer != '0) return;
			if (rx == RX_SENDING) next_half();
			else stop_seen();
		endfunction

		function void note_event(dmt_in_t ev);
			dmt_out_t o;
			case (ev.func)
				FUNC_EDGE: begin
					if (ev.line_level) fall(ev.time_us);
					else rise(ev.time_us);
				end
				FUNC_TICK: tick();
				FUNC_SEND: begin
					tx_bits = ev.send_pattern;
					tx_left = (ev.send_count > 32) ? 32 : ev.send_count;
					rx = RX_SENDING;
					tx = TX_START;
					drive = 1'b1;
					watch = 1'b0;
					timer = load(half_ticks);
				end
				default: begin
					if (rx == RX_READY || rx == RX_ERROR) begin
						rx = RX_IDLE;
						err_code = ERR_NONE;
						err_class = CL_SHORT;
						err_state = RX_IDLE;
					end
				end
			endcase
			o.drive_short   = drive;
			o.receive_state = rx;
			o.send_status   = tx;
			o.frame_value   = frame;
			o.frame_bits    = nbits;
			o.error_code    = err_code;
			o.error_timing  = err_class;
			o.error_state   = err_state;
			status_q.push_back(o);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				fails++;
				if (fails <= MAX_MSGS) $error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_beat(dmt_out_t got);
			dmt_out_t want;
			if (status_q.size() == 0) begin
				fails++;
				if (fails <= MAX_MSGS) $error("status beat with no event outstanding");
				return;
			end
			want = status_q.pop_front();
			cmp_field("drive_short", want.drive_short, got.drive_short);
			cmp_field("receive_state", want.receive_state, got.receive_state);
			cmp_field("send_status", want.send_status, got.send_status);
			cmp_field("frame_value", want.frame_value, got.frame_value);
			cmp_field("frame_bits", want.frame_bits, got.frame_bits);
			cmp_field("error_code", want.error_code, got.error_code);
			cmp_field("error_timing", want.error_timing, got.error_timing);
			cmp_field("error_state", want.error_state, got.error_state);
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	dmt_in_t     in_data  = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	dmt_out_t    out_data;
	logic        cfg_we   = 1'b0;
	logic [2:0]  cfg_idx  = '0;
	logic [15:0] cfg_data = '0;

	xcvr_scoreboard sb = new();

	logic [31:0] now_us = '0;
	bit          tight = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned items_sent = 0;
	int unsigned holds_done = 0;
	int unsigned quiet_cycles = 0;

	dali_manchester_transceiver_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_beat(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else if (arst_n) quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$error("no beat moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int n, r;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_ready <= 1'b1;
					n = $urandom_range(1, 30);
				end else if (r < 95) begin
					out_ready <= 1'b0;
					n = $urandom_range(1, 4);
				end else begin
					out_ready <= 1'b0;
					n = $urandom_range(20, 80);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic int sender_gap();
		int r;
		if (tight) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic dmt_in_t mk_ev(func_t f, logic lv, logic [31:0] t, logic [31:0] p,
			logic [5:0] c);
		dmt_in_t ev;
		ev.func = f;
		ev.line_level = lv;
		ev.time_us = t;
		ev.send_pattern = p;
		ev.send_count = c;
		return ev;
	endfunction

	function automatic dmt_in_t tick_ev();
		return mk_ev(FUNC_TICK, $urandom_range(0, 1), $urandom(), $urandom(),
			$urandom_range(0, 63));
	endfunction

	function automatic dmt_in_t ack_ev();
		return mk_ev(FUNC_ACK, $urandom_range(0, 1), $urandom(), $urandom(),
			$urandom_range(0, 63));
	endfunction

	// edge spacing for a run of one or two half bits, sometimes off on purpose
	function automatic logic [31:0] spacing_us(int run, int bad_pct);
		int lo, hi;
		if ($urandom_range(0, 99) < bad_pct) return $urandom_range(0, 1200 + 2 * sb.lim_two_max);
		if (run == 1) begin
			lo = sb.lim_half_min;
			hi = sb.lim_half_max;
		end else begin
			lo = sb.lim_two_min;
			hi = sb.lim_two_max;
		end
		if (hi <= lo) return $urandom_range(0, 70000);
		return $urandom_range(lo, hi - 1);
	endfunction

	task automatic send_event(input dmt_in_t ev);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_event(ev);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input logic [15:0] hmin, hmax, tmin, tmax, hticks, sticks);
		logic [15:0] vals [6];
		logic [2:0]  idx [6];
		vals = '{hmin, hmax, tmin, tmax, hticks, sticks};
		idx = '{REG_HALF_BIT_MIN, REG_HALF_BIT_MAX, REG_TWO_HALF_MIN, REG_TWO_HALF_MAX,
			REG_HALF_TICKS, REG_STOP_TICKS};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic sane_config();
		logic [15:0] a, b, c, d;
		a = $urandom_range(40, 400);
		b = a + $urandom_range(40, 300);
		c = b + $urandom_range(0, 120);
		d = c + $urandom_range(80, 600);
		apply_config(a, b, c, d, $urandom_range(0, 4), $urandom_range(0, 9));
	endtask

	// one Manchester frame as line edges, then ticks while the stop timer runs, up to 80 of them
	task automatic rx_frame(input int nbits, input int bad_pct);
		bit lv [$];
		bit prev, first;
		int run, n;
		lv.push_back(1'b0);
		lv.push_back(1'b1);
		for (int i = 0; i < nbits; i++) begin
			if ($urandom_range(0, 1)) begin
				lv.push_back(1'b0);
				lv.push_back(1'b1);
			end else begin
				lv.push_back(1'b1);
				lv.push_back(1'b0);
			end
		end
		lv.push_back(1'b1);
		prev = 1'b1;
		first = 1'b1;
		run = 0;
		now_us = $urandom();
		foreach (lv[i]) begin
			if (lv[i] != prev) begin
				if (!first) now_us += spacing_us(run, bad_pct);
				if ($urandom_range(0, 99) < 4) send_event(tick_ev());
				// line_level 1 means the bus is pulled low
				send_event(mk_ev(FUNC_EDGE, ~lv[i], now_us, $urandom(), $urandom_range(0, 63)));
				first = 1'b0;
				run = 1;
				prev = lv[i];
			end else run++;
		end
		n = 0;
		while (sb.timer != '0 && sb.rx != RX_SENDING && n < 80) begin
			send_event(tick_ev());
			n++;
		end
		repeat ($urandom_range(0, 2)) send_event(tick_ev());
		if ($urandom_range(0, 9) < 7) send_event(ack_ev());
	endtask

	task automatic tx_sequence(input logic [5:0] cnt, input int hit_pct, input int cap);
		int n;
		send_event(mk_ev(FUNC_SEND, $urandom_range(0, 1), $urandom(), $urandom(), cnt));
		n = 0;
		while (sb.rx == RX_SENDING && n < cap) begin
			// a stray edge while sending; a low one during a released half collides
			if ($urandom_range(0, 99) < hit_pct) begin
				now_us += $urandom_range(1, 600);
				send_event(mk_ev(FUNC_EDGE, $urandom_range(0, 1), now_us, $urandom(),
					$urandom_range(0, 63)));
			end
			send_event(tick_ev());
			n++;
		end
	endtask

	task automatic run_phase(input int n_items, input bit extreme);
		int stop_at, r, len;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			tight = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				len = $urandom_range(0, 99);
				if (len < 4) len = $urandom_range(64, 70);
				else if (len < 12) len = $urandom_range(33, 40);
				else len = $urandom_range(1, 24);
				rx_frame(len, extreme ? 30 : 6);
			end else if (r < 65) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
				tx_sequence(len, 3, extreme ? 20 : 300);
			end else if (r < 75) send_event(ack_ev());
			else if (r < 78) drain_results();
			else if (r < 80) hold_req = 1'b1;
			else begin
				repeat ($urandom_range(1, 5))
					send_event(mk_ev(func_t'($urandom_range(0, 3)), $urandom_range(0, 1),
						$urandom(), $urandom(), $urandom_range(0, 63)));
			end
		end
		tight = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: ack and tick with nothing to do, a bad data half, a one-bit frame
		send_event(ack_ev());
		send_event(tick_ev());
		send_event(mk_ev(FUNC_EDGE, 1'b0, 32'hFFFF_FFFF, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b1, 32'd0, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b0, 32'd400, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b1, 32'd800, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b0, 32'd1600, '0, '0));
		send_event(ack_ev());
		send_event(mk_ev(FUNC_EDGE, 1'b1, 32'd10000, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b0, 32'd10400, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b1, 32'd10800, '0, '0));
		send_event(mk_ev(FUNC_EDGE, 1'b0, 32'd11200, '0, '0));
		repeat (4) send_event(tick_ev());
		send_event(ack_ev());
		// oversized count, restart while busy, then a collision
		send_event(mk_ev(FUNC_SEND, 1'b0, '0, 32'hFFFF_FFFF, 6'd63));
		send_event(mk_ev(FUNC_SEND, 1'b0, '0, 32'h0000_0001, 6'd1));
		send_event(tick_ev());
		send_event(mk_ev(FUNC_EDGE, 1'b1, 32'd20000, '0, '0));
		send_event(tick_ev());
		// empty send runs straight to the stop wait
		send_event(mk_ev(FUNC_SEND, 1'b1, '0, '0, 6'd0));
		repeat (6) send_event(tick_ev());
		drain_results();

		apply_config(RST_HALF_BIT_MIN, RST_HALF_BIT_MAX, RST_TWO_HALF_MIN, RST_TWO_HALF_MAX,
			RST_HALF_TICKS, RST_STOP_TICKS);
		hold_req = 1'b1;
		run_phase(170, 1'b0);
		drain_results();
		sane_config();
		run_phase(110, 1'b0);
		drain_results();
		apply_config('0, '0, '0, '0, '0, '0);
		run_phase(40, 1'b1);
		drain_results();
		apply_config('1, '1, '1, '1, '1, '1);
		run_phase(30, 1'b1);
		drain_results();
		sane_config();
		run_phase(150, 1'b0);
		drain_results();
		repeat (10) @(posedge clk);

		$display("covered %0d events over five timing sets (reset, random, all-zero, all-ones)",
			items_sent);
		$display("frames %0d, rx errors %0d, sends done %0d, collisions %0d, hold-offs %0d",
			sb.frames_ok, sb.rx_errors, sb.sends_ok, sb.collisions, holds_done);
		if (sb.fails == 0 && sb.pending() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
